// File: rtl/grid_christoffel_stencil_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Christoffel stencil checker
// Clocked implication forms shared by the checker module.
// ----------------------------------------------------------------------------
`ifndef GRID_CHRISTOFFEL_STENCIL_ASSERT_SVH
`define GRID_CHRISTOFFEL_STENCIL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GCS_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("stencil check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during reset.
`define GCS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("stencil check failed: next-cycle rule");

`endif

// File: rtl/gcs_pkg.sv
// ----------------------------------------------------------------------------
// gcs_pkg
// Types, constants and helpers for the Christoffel symbol stencil.
// ----------------------------------------------------------------------------
package gcs_pkg;

    localparam int DEF_MAX_ROW_CELLS = 256;
    localparam int DEF_MAX_ROWS      = 1024;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int WORD_W      = 32;
    localparam int ROW_OUT_W   = 10;
    localparam int COL_OUT_W   = 8;
    localparam int STEP_W      = 31;
    localparam int ROWCNT_W    = 11;
    localparam int COLCNT_W    = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_COMP    = 6;
    localparam int TERM_W      = WORD_W + 2;
    localparam int SPROD_W     = WORD_W + TERM_W;
    localparam int SSUM_W      = SPROD_W + 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ANGULAR = 2'd3;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET = 11'd3;
    localparam logic [COLCNT_W-1:0] COL_COUNT_RESET = 9'd3;
    localparam logic [STEP_W-1:0]   STEP_RESET      = 31'd65536;

    // Axis codes for derivatives
    localparam logic AXIS_RADIAL  = 1'b0;
    localparam logic AXIS_ANGULAR = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [NUM_COMP-1:0][WORD_W-1:0] comp_vec_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] metric_rr;
        logic signed [WORD_W-1:0] metric_rt;
        logic signed [WORD_W-1:0] metric_rp;
        logic signed [WORD_W-1:0] metric_tt;
        logic signed [WORD_W-1:0] metric_tp;
        logic signed [WORD_W-1:0] metric_pp;
        logic signed [WORD_W-1:0] inverse_rr;
        logic signed [WORD_W-1:0] inverse_rt;
        logic signed [WORD_W-1:0] inverse_rp;
        logic signed [WORD_W-1:0] inverse_tt;
        logic signed [WORD_W-1:0] inverse_tp;
        logic signed [WORD_W-1:0] inverse_pp;
    } in_beat_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0]     cell_row;
        logic [COL_OUT_W-1:0]     cell_column;
        logic [1:0]               upper_index;
        logic [1:0]               lower_first;
        logic [1:0]               lower_second;
        logic signed [WORD_W-1:0] symbol_value;
        logic                     saturated;
        logic                     last_of_cell;
    } out_beat_t;

    // Tag that travels alongside one symbol through the pipeline
    typedef struct packed {
        logic                 valid;
        logic [ROW_OUT_W-1:0] cell_row;
        logic [COL_OUT_W-1:0] cell_column;
        logic [1:0]           k;
        logic [1:0]           i;
        logic [1:0]           j;
        logic                 dclip;
        logic                 last;
    } sym_tag_t;

    // Component slot of symmetric index pair (a, b)
    function automatic logic [2:0] comp_of(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] lo;
        logic [1:0] hi;
        logic [2:0] res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ({lo, hi})
            4'b0000: res = 3'd0;
            4'b0001: res = 3'd1;
            4'b0010: res = 3'd2;
            4'b0101: res = 3'd3;
            4'b0110: res = 3'd4;
            default: res = 3'd5;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/gcs_deriv_lane.sv
// ----------------------------------------------------------------------------
// gcs_deriv_lane
// One metric component: difference, scale by step, floor shift, saturate.
// ----------------------------------------------------------------------------
module gcs_deriv_lane
    import gcs_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              axis,
    input  word_t             plus_val,
    input  word_t             minus_val,
    input  logic [STEP_W-1:0] step,
    output word_t             deriv_r,
    output word_t             deriv_t,
    output logic              clip_r,
    output logic              clip_t
);

    logic               v1_reg, v2_reg;
    logic               ax1_reg, ax2_reg;
    logic signed [32:0] diff_reg;
    logic [STEP_W-1:0]  step_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;
    logic               fits;
    word_t              sat_val;
    word_t              d_reg [2];
    logic               c_reg [2];

    always_comb
    begin
        shifted = prod_reg >>> FRACTION_BITS;
        fits    = (&shifted[63:31]) || !(|shifted[63:31]);
        if (fits)
        begin
            sat_val = shifted[31:0];
        end
        else if (shifted[63])
        begin
            sat_val = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= {plus_val[31], plus_val} - {minus_val[31], minus_val};
        step_reg <= step;
        ax1_reg  <= axis;
        prod_reg <= diff_reg * $signed({1'b0, step_reg});
        ax2_reg  <= ax1_reg;
        if (v2_reg)
        begin
            d_reg[ax2_reg] <= sat_val;
            c_reg[ax2_reg] <= !fits;
        end
    end

    assign deriv_r = d_reg[AXIS_RADIAL];
    assign deriv_t = d_reg[AXIS_ANGULAR];
    assign clip_r  = c_reg[AXIS_RADIAL];
    assign clip_t  = c_reg[AXIS_ANGULAR];

endmodule

// File: rtl/gcs_sym_lane.sv
// ----------------------------------------------------------------------------
// gcs_sym_lane
// One contraction index l: build the metric-derivative term, multiply by G[k][l].
// ----------------------------------------------------------------------------
module gcs_sym_lane
    import gcs_pkg::*;
#(
    parameter logic [1:0] LANE_L = 2'd0
)
(
    input  logic                      clk,
    input  logic                      adv,
    input  logic [1:0]                i,
    input  logic [1:0]                j,
    input  comp_vec_t                 d_r,
    input  comp_vec_t                 d_t,
    input  word_t                     g,
    output logic signed [SPROD_W-1:0] prod
);

    logic signed [TERM_W-1:0]  t_next, t_reg;
    word_t                     g_reg;
    logic signed [SPROD_W-1:0] prod_reg;

    function automatic logic signed [TERM_W-1:0] pick(input comp_vec_t dr,
                                                       input comp_vec_t dt,
                                                       input logic [1:0] ax,
                                                       input logic [2:0] slot);
        logic [WORD_W-1:0] w;
        w = (ax == 2'd0) ? dr[slot] : dt[slot];
        return {{(TERM_W-WORD_W){w[WORD_W-1]}}, w};
    endfunction

    always_comb
    begin
        t_next = '0;
        if (i != 2'd2)
        begin
            t_next = t_next + pick(d_r, d_t, i, comp_of(j, LANE_L));
        end
        if (j != 2'd2)
        begin
            t_next = t_next + pick(d_r, d_t, j, comp_of(i, LANE_L));
        end
        if (LANE_L != 2'd2)
        begin
            t_next = t_next - pick(d_r, d_t, LANE_L, comp_of(i, j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= t_next;
            g_reg    <= g;
            prod_reg <= t_reg * g_reg;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/gcs_merge.sv
// ----------------------------------------------------------------------------
// gcs_merge
// Sum the lane products, shift out the fraction bits and halve with floor, saturate and hold the output beat.
// ----------------------------------------------------------------------------
module gcs_merge
    import gcs_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  sym_tag_t                  tag,
    input  logic signed [SPROD_W-1:0] p0,
    input  logic signed [SPROD_W-1:0] p1,
    input  logic signed [SPROD_W-1:0] p2,
    output logic                      valid,
    output out_beat_t                 beat
);

    logic signed [SSUM_W-1:0] sum;
    logic signed [SSUM_W-1:0] shifted;
    logic                     fits;
    word_t                    sat_val;
    logic                     valid_reg;
    out_beat_t                beat_reg;

    always_comb
    begin
        sum     = SSUM_W'(p0) + SSUM_W'(p1) + SSUM_W'(p2);
        shifted = sum >>> (FRACTION_BITS + 1);
        fits    = (&shifted[SSUM_W-1:31]) || !(|shifted[SSUM_W-1:31]);
        if (fits)
        begin
            sat_val = shifted[31:0];
        end
        else if (shifted[SSUM_W-1])
        begin
            sat_val = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg.cell_row     <= tag.cell_row;
            beat_reg.cell_column  <= tag.cell_column;
            beat_reg.upper_index  <= tag.k;
            beat_reg.lower_first  <= tag.i;
            beat_reg.lower_second <= tag.j;
            beat_reg.symbol_value <= sat_val;
            beat_reg.saturated    <= tag.dclip | !fits;
            beat_reg.last_of_cell <= tag.last;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

// File: rtl/grid_christoffel_stencil.sv
// ----------------------------------------------------------------------------
// grid_christoffel_stencil
// Christoffel symbols of a 3x3 metric over an (r, theta) grid by central
// differences, with two line stores and lane-parallel arithmetic.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  in_data   (in_beat_t, one cell)
//  out       output     out_valid/out_stall  out_data  (out_beat_t, one symbol)
//  config    input      write_enable         register_index, write_data
//
//  An interior cell passes accept, the line-store states (the single read
//  port of the metric store is visited three times), the derivative lane
//  states, then 27 symbol issues, one per cycle through the lanes unless
//  out stalls. A border cell ends after the line-store states with no beat.
//  Reset clears control, positions and configuration; the line stores are
//  not cleared. A stall on out freezes the symbol pipeline in place; input
//  accept resumes once all 27 symbols of a cell have been issued.
//
module grid_christoffel_stencil
    import gcs_pkg::*;
#(
    parameter int MAX_ROW_CELLS = DEF_MAX_ROW_CELLS,
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_beat_t            out_data,
    input  logic                 write_enable,
    input  logic [CFG_IDX_W-1:0] register_index,
    input  logic [STEP_W-1:0]    write_data
);

    localparam int CW   = $clog2(MAX_ROW_CELLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int MAW  = CW + 1;
    localparam int LINE = NUM_COMP * WORD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_UP,
        ST_RD_LF,
        ST_RD_RT,
        ST_WRITE,
        ST_DER_R,
        ST_DER_T,
        ST_DER_WAIT,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [ROWCNT_W-1:0] row_count_reg;
    logic [COLCNT_W-1:0] col_count_reg;
    logic [STEP_W-1:0]   step_r_reg, step_t_reg;
    logic [RW-1:0]       row_pos_reg;
    logic [CW-1:0]       col_pos_reg;
    logic [RW-1:0]       r_reg;
    logic [CW-1:0]       c_reg;
    logic                interior_reg;
    logic                wait_reg;
    logic [1:0]          k_reg, i_reg, j_reg;

    logic [31:0]         rows_eff, cols_eff;
    logic                accept, adv, issue, last_issue, interior_now;

    // Payload holding registers
    logic [LINE-1:0]     m_reg, inv_reg;
    comp_vec_t           up_reg, lf_reg, rt_reg, ginv_reg;

    // Line stores
    logic [LINE-1:0]     metric_mem [2**MAW];
    logic [LINE-1:0]     inverse_mem [2**CW];
    logic [LINE-1:0]     m_rdata_reg, i_rdata_reg;
    logic [MAW-1:0]      m_raddr;
    logic                parity;

    // Lane results
    comp_vec_t           d_r, d_t;
    logic [NUM_COMP-1:0] clip_r, clip_t;
    logic                dclip;

    sym_tag_t            tag1_next, tag1_reg, tag2_reg;
    logic signed [SPROD_W-1:0] prod [3];
    word_t               g_sel [3];

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign adv      = !(out_valid && out_stall);
    assign issue    = (state_reg == ST_EMIT) && adv;
    assign last_issue = (k_reg == 2'd2) && (i_reg == 2'd2) && (j_reg == 2'd2);
    assign parity   = r_reg[0];

    // Clamp the counts to the supported grid
    always_comb
    begin
        rows_eff = 32'(row_count_reg);
        if (rows_eff < 32'd3)
        begin
            rows_eff = 32'd3;
        end
        else if (rows_eff > 32'(MAX_ROWS))
        begin
            rows_eff = 32'(MAX_ROWS);
        end
        cols_eff = 32'(col_count_reg);
        if (cols_eff < 32'd3)
        begin
            cols_eff = 32'd3;
        end
        else if (cols_eff > 32'(MAX_ROW_CELLS))
        begin
            cols_eff = 32'(MAX_ROW_CELLS);
        end
    end

    assign interior_now = (32'(row_pos_reg) >= 32'd2) && (32'(row_pos_reg) < rows_eff)
                       && (col_pos_reg != '0) && (32'(col_pos_reg) + 32'd1 < cols_eff);

    // Control: state, positions, configuration, symbol counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= ROW_COUNT_RESET;
            col_count_reg <= COL_COUNT_RESET;
            step_r_reg    <= STEP_RESET;
            step_t_reg    <= STEP_RESET;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            interior_reg  <= 1'b0;
            wait_reg      <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            if (write_enable)
            begin
                unique case (register_index)
                    REG_ROW_COUNT:   row_count_reg <= write_data[ROWCNT_W-1:0];
                    REG_COL_COUNT:   col_count_reg <= write_data[COLCNT_W-1:0];
                    REG_INV_RADIAL:  step_r_reg    <= write_data;
                    REG_INV_ANGULAR: step_t_reg    <= write_data;
                    default:         ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        interior_reg <= interior_now;
                        // Advance raster position; wrap past the end of a row or grid
                        if (32'(col_pos_reg) + 32'd1 >= cols_eff)
                        begin
                            col_pos_reg <= '0;
                            if (32'(row_pos_reg) + 32'd1 >= rows_eff)
                            begin
                                row_pos_reg <= '0;
                            end
                            else
                            begin
                                row_pos_reg <= row_pos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_pos_reg <= col_pos_reg + 1'b1;
                        end
                        state_reg <= ST_RD_UP;
                    end
                end
                ST_RD_UP: state_reg <= ST_RD_LF;
                ST_RD_LF: state_reg <= ST_RD_RT;
                ST_RD_RT: state_reg <= ST_WRITE;
                ST_WRITE: state_reg <= interior_reg ? ST_DER_R : ST_IDLE;
                ST_DER_R: state_reg <= ST_DER_T;
                ST_DER_T:
                begin
                    wait_reg  <= 1'b0;
                    state_reg <= ST_DER_WAIT;
                end
                ST_DER_WAIT:
                begin
                    // Hold while the angular result drains from the lanes
                    wait_reg <= 1'b1;
                    if (wait_reg)
                    begin
                        k_reg     <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        if (j_reg != 2'd2)
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                        else
                        begin
                            j_reg <= '0;
                            if (i_reg != 2'd2)
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                            else
                            begin
                                i_reg <= '0;
                                k_reg <= k_reg + 1'b1;
                            end
                        end
                        if (last_issue)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg   <= {in_data.metric_pp, in_data.metric_tp, in_data.metric_tt,
                        in_data.metric_rp, in_data.metric_rt, in_data.metric_rr};
            inv_reg <= {in_data.inverse_pp, in_data.inverse_tp, in_data.inverse_tt,
                        in_data.inverse_rp, in_data.inverse_rt, in_data.inverse_rr};
            r_reg   <= row_pos_reg;
            c_reg   <= col_pos_reg;
        end
        if (state_reg == ST_RD_LF)
        begin
            up_reg <= m_rdata_reg;
        end
        if (state_reg == ST_RD_RT)
        begin
            lf_reg   <= m_rdata_reg;
            ginv_reg <= i_rdata_reg;
        end
        if (state_reg == ST_WRITE)
        begin
            rt_reg <= m_rdata_reg;
        end
    end

    // Metric line store: current row at parity of r, previous row at the other
    always_comb
    begin
        case (state_reg)
            ST_RD_LF: m_raddr = {~parity, c_reg - 1'b1};
            ST_RD_RT: m_raddr = {~parity, c_reg + 1'b1};
            default:  m_raddr = {parity, c_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            metric_mem[{parity, c_reg}] <= m_reg;
        end
        m_rdata_reg <= metric_mem[m_raddr];
    end

    // Inverse line store: one row, read before this cell overwrites it
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            inverse_mem[c_reg] <= inv_reg;
        end
        i_rdata_reg <= inverse_mem[c_reg];
    end

    // Derivative lanes, one per metric component
    for (genvar a = 0; a < NUM_COMP; a++)
    begin : g_deriv
        logic  start_a;
        logic  axis_a;
        word_t plus_a, minus_a;

        assign start_a = (state_reg == ST_DER_R) || (state_reg == ST_DER_T);
        assign axis_a  = (state_reg == ST_DER_T) ? AXIS_ANGULAR : AXIS_RADIAL;
        assign plus_a  = (state_reg == ST_DER_T) ? rt_reg[a] : m_reg[a*WORD_W +: WORD_W];
        assign minus_a = (state_reg == ST_DER_T) ? lf_reg[a] : up_reg[a];

        gcs_deriv_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (start_a),
            .axis      (axis_a),
            .plus_val  (plus_a),
            .minus_val (minus_a),
            .step      ((state_reg == ST_DER_T) ? step_t_reg : step_r_reg),
            .deriv_r   (d_r[a]),
            .deriv_t   (d_t[a]),
            .clip_r    (clip_r[a]),
            .clip_t    (clip_t[a])
        );
    end

    assign dclip = (|clip_r) || (|clip_t);

    // Issue tag for the symbol at (k, i, j)
    always_comb
    begin
        tag1_next.valid       = issue;
        tag1_next.cell_row    = ROW_OUT_W'(r_reg - 1'b1);
        tag1_next.cell_column = COL_OUT_W'(c_reg);
        tag1_next.k           = k_reg;
        tag1_next.i           = i_reg;
        tag1_next.j           = j_reg;
        tag1_next.dclip       = dclip;
        tag1_next.last        = last_issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
        end
    end

    // Contraction lanes, one per index l
    for (genvar l = 0; l < 3; l++)
    begin : g_sym
        assign g_sel[l] = ginv_reg[comp_of(k_reg, 2'(l))];

        gcs_sym_lane #(
            .LANE_L (2'(l))
        ) u_lane (
            .clk  (clk),
            .adv  (adv),
            .i    (i_reg),
            .j    (j_reg),
            .d_r  (d_r),
            .d_t  (d_t),
            .g    (g_sel[l]),
            .prod (prod[l])
        );
    end

    gcs_merge #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .tag   (tag2_reg),
        .p0    (prod[0]),
        .p1    (prod[1]),
        .p2    (prod[2]),
        .valid (out_valid),
        .beat  (out_data)
    );

endmodule

// File: rtl/gcs_checker.sv
// ----------------------------------------------------------------------------
// gcs_checker
// Port-level checks on the stencil, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_christoffel_stencil_assert.svh"

module gcs_checker
    import gcs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);

    `GCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `GCS_ASSERT_SAME(a_last_idx, out_valid && out_data.last_of_cell, out_data.upper_index == 2'd2 && out_data.lower_first == 2'd2 && out_data.lower_second == 2'd2)
    `GCS_ASSERT_SAME(a_idx_range, out_valid, out_data.upper_index != 2'd3 && out_data.lower_first != 2'd3 && out_data.lower_second != 2'd3)
    `GCS_ASSERT_NEXT(a_busy_after, in_valid && !in_stall, in_stall)

endmodule

bind grid_christoffel_stencil gcs_checker u_gcs_checker (.*);

// File: dv/tb_grid_christoffel_stencil.sv
// ----------------------------------------------------------------------------
// tb_grid_christoffel_stencil
// Feeds whole grids of metric cells through the Christoffel stencil, predicts
// every symbol in a scoreboard and checks each result beat field by field,
// under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
import gcs_pkg::*;

class symbol_scoreboard;
    int unsigned row_cfg;
    int unsigned col_cfg;
    longint      radial_step;
    longint      angular_step;
    longint      metric_rows [2][256][6];
    longint      inverse_row [256][6];
    int unsigned row_pos;
    int unsigned col_pos;
    out_beat_t   pending [$];
    int          fails;

    function void reset_state();
        row_cfg      = ROW_COUNT_RESET;
        col_cfg      = COL_COUNT_RESET;
        radial_step  = STEP_RESET;
        angular_step = STEP_RESET;
        row_pos      = 0;
        col_pos      = 0;
        pending.delete();
        fails        = 0;
    endfunction

    function int unsigned grid_rows();
        return (row_cfg < 3) ? 3 : ((row_cfg > 1024) ? 1024 : row_cfg);
    endfunction

    function int unsigned grid_cols();
        return (col_cfg < 3) ? 3 : ((col_cfg > 256) ? 256 : col_cfg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
        case (idx)
            REG_ROW_COUNT:   row_cfg = val[ROWCNT_W-1:0];
            REG_COL_COUNT:   col_cfg = val[COLCNT_W-1:0];
            REG_INV_RADIAL:  radial_step = val;
            REG_INV_ANGULAR: angular_step = val;
        endcase
    endfunction

    function int unsigned slot(int unsigned a, int unsigned b);
        int unsigned lo;
        int unsigned hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == 0) return hi;
        if (lo == 1) return hi + 2;
        return 5;
    endfunction

    // Derivative: exact product, floor shift, clip to 32 bit.
    function longint deriv(longint diff, longint step, inout bit clip);
        longint p;
        p = (diff * step) >>> 16;
        if (p > 64'sd2147483647) begin clip = 1; return 64'sd2147483647; end
        if (p < -64'sd2147483648) begin clip = 1; return -64'sd2147483648; end
        return p;
    endfunction

    function void note_input(in_beat_t beat_in);
        logic [383:0] flat;
        longint      m [6];
        longint      inv [6];
        longint      d [2][6];
        bit          dclip;
        bit          clip;
        int unsigned r;
        int unsigned c;
        int unsigned cur;
        logic signed [95:0] acc;
        logic signed [95:0] sh;
        longint      t;
        out_beat_t   o;
        flat = beat_in;
        for (int a = 0; a < 6; a++)
        begin
            m[a]   = longint'($signed(flat[383 - 32*a -: 32]));
            inv[a] = longint'($signed(flat[191 - 32*a -: 32]));
        end
        r = row_pos;
        c = col_pos % 256;
        cur = r & 1;
        if (r >= 2 && r < grid_rows() && c >= 1 && c + 1 < grid_cols())
        begin
            dclip = 0;
            for (int a = 0; a < 6; a++)
            begin
                d[0][a] = deriv(m[a] - metric_rows[cur][c][a], radial_step, dclip);
                d[1][a] = deriv(metric_rows[cur^1][c+1][a] - metric_rows[cur^1][c-1][a],
                                angular_step, dclip);
            end
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                    begin
                        acc = 0;
                        clip = dclip;
                        for (int l = 0; l < 3; l++)
                        begin
                            t = 0;
                            if (i < 2) t += d[i][slot(j, l)];
                            if (j < 2) t += d[j][slot(i, l)];
                            if (l < 2) t -= d[l][slot(i, j)];
                            acc += 96'(inverse_row[c][slot(k, l)]) * 96'(t);
                        end
                        sh = acc >>> 17;
                        if (sh > 96'sd2147483647)
                        begin
                            clip = 1;
                            sh = 96'sd2147483647;
                        end
                        else if (sh < -96'sd2147483648)
                        begin
                            clip = 1;
                            sh = -96'sd2147483648;
                        end
                        o.cell_row     = ROW_OUT_W'(r - 1);
                        o.cell_column  = COL_OUT_W'(c);
                        o.upper_index  = 2'(k);
                        o.lower_first  = 2'(i);
                        o.lower_second = 2'(j);
                        o.symbol_value = sh[31:0];
                        o.saturated    = clip;
                        o.last_of_cell = (k == 2 && i == 2 && j == 2);
                        pending.push_back(o);
                    end
        end
        for (int a = 0; a < 6; a++)
        begin
            metric_rows[cur][c][a] = m[a];
            inverse_row[c][a]      = inv[a];
        end
        if (col_pos + 1 >= grid_cols())
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= grid_rows()) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endfunction

    function void check_result(out_beat_t got);
        out_beat_t exp;
        if (pending.size() == 0)
        begin
            $error("unexpected symbol beat %p", got);
            fails++;
            return;
        end
        exp = pending.pop_front();
        if (got.cell_row != exp.cell_row)
        begin
            $error("cell_row exp %0d got %0d", exp.cell_row, got.cell_row); fails++;
        end
        if (got.cell_column != exp.cell_column)
        begin
            $error("cell_column exp %0d got %0d", exp.cell_column, got.cell_column); fails++;
        end
        if (got.upper_index != exp.upper_index)
        begin
            $error("upper_index exp %0d got %0d", exp.upper_index, got.upper_index); fails++;
        end
        if (got.lower_first != exp.lower_first)
        begin
            $error("lower_first exp %0d got %0d", exp.lower_first, got.lower_first); fails++;
        end
        if (got.lower_second != exp.lower_second)
        begin
            $error("lower_second exp %0d got %0d", exp.lower_second, got.lower_second);
            fails++;
        end
        if (got.symbol_value != exp.symbol_value)
        begin
            $error("symbol_value exp %0d got %0d", exp.symbol_value, got.symbol_value);
            fails++;
        end
        if (got.saturated != exp.saturated)
        begin
            $error("saturated exp %0d got %0d", exp.saturated, got.saturated); fails++;
        end
        if (got.last_of_cell != exp.last_of_cell)
        begin
            $error("last_of_cell exp %0d got %0d", exp.last_of_cell, got.last_of_cell);
            fails++;
        end
    endfunction
endclass

module tb_grid_christoffel_stencil;

    // Cell content styles
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_SMALL   = 1;
    localparam int FILL_EXTREME = 2;
    localparam int FILL_ZERO    = 3;

    localparam int HOLD_CYCLES  = 2000;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    in_beat_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    out_beat_t            out_data;
    logic                 write_enable = 0;
    logic [CFG_IDX_W-1:0] register_index = REG_ROW_COUNT;
    logic [STEP_W-1:0]    write_data = '0;

    symbol_scoreboard sb;
    int idle_pct   = 0;
    int stall_pct  = 0;
    bit hold_go    = 0;
    bit hold_done  = 0;
    int hold_count = 0;
    int cells_sent;

    grid_christoffel_stencil u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data)
    );

    always #5 clk = ~clk;

    // Receiver: once requested, hold off for a long stretch, otherwise stall at random.
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check every symbol beat that leaves the block.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    function automatic logic [31:0] pick_word(int fill);
        logic [31:0] w;
        case (fill)
            FILL_RANDOM: w = $urandom;
            FILL_SMALL:  w = 32'($signed($urandom_range(262144)) - 131072);
            FILL_EXTREME:
                case ($urandom_range(3))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'hFFFF_FFFF;
                    default: w = 32'h0000_0000;
                endcase
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic in_beat_t make_cell(int fill);
        logic [383:0] flat;
        for (int a = 0; a < 12; a++)
            flat[383 - 32*a -: 32] = pick_word(fill);
        return in_beat_t'(flat);
    endfunction

    // Offer one beat at the falling edge, hold it until it is taken.
    task automatic send_cell(in_beat_t beat_in);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat_in;
        do @(posedge clk); while (in_stall);
        sb.note_input(beat_in);
        cells_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
        @(negedge clk);
        in_valid       = 1'b0;
        write_enable   = 1'b1;
        register_index = idx;
        write_data     = val;
        @(negedge clk);
        write_enable   = 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Wait for every predicted symbol, then let a border cell finish.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Send one complete grid so positions end back at the origin.
    task automatic send_grid(int fill, bit pause_between);
        int unsigned n;
        n = sb.grid_rows() * sb.grid_cols();
        for (int unsigned q = 0; q < n; q++)
        begin
            send_cell(make_cell(($urandom_range(9) == 0) ? FILL_EXTREME : fill));
            if (pause_between && (q % sb.grid_cols()) == sb.grid_cols() - 1)
                drain();
        end
    endtask

    // Send a fixed number of cells, wherever the position stands.
    task automatic send_cells(int fill, int unsigned n);
        for (int unsigned q = 0; q < n; q++)
            send_cell(make_cell(fill));
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(4))
            0: return 31'h7FFF_FFFF;
            1: return 31'd1;
            2: return STEP_W'($urandom_range(32, 262144));
            default: return STEP_W'($urandom);
        endcase
    endfunction

    initial
    begin
        #50_000_000;
        $display("tb_grid_christoffel_stencil: FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        cells_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset geometry with extreme, zero and small cells.
        send_grid(FILL_EXTREME, 0);
        send_grid(FILL_ZERO, 0);
        send_grid(FILL_SMALL, 0);
        drain();
        // Zero steps kill both derivatives.
        write_reg(REG_INV_RADIAL, '0);
        write_reg(REG_INV_ANGULAR, '0);
        send_grid(FILL_RANDOM, 0);
        drain();

        // Random phases: no idling, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 8 : 0;
            stall_pct = (ph == 2) ? 47 : (ph == 3) ? 8 : 0;
            cells_sent = 0;
            while (cells_sent < 60)
            begin
                write_reg(REG_ROW_COUNT, STEP_W'($urandom_range(3, 6)));
                write_reg(REG_COL_COUNT, STEP_W'($urandom_range(3, 8)));
                write_reg(REG_INV_RADIAL, pick_step());
                write_reg(REG_INV_ANGULAR, pick_step());
                // Hold the receiver off long enough to back the block up.
                if (ph == 0 && cells_sent == 0)
                    hold_go = 1'b1;
                send_grid(($urandom_range(3) == 0) ? FILL_RANDOM : FILL_SMALL, ph == 1);
                drain();
            end
        end

        // Clamped geometry: a huge row count runs as the row limit, zero columns as three.
        idle_pct  = 8;
        stall_pct = 8;
        write_reg(REG_ROW_COUNT, STEP_W'(11'h7FF));
        write_reg(REG_COL_COUNT, '0);
        write_reg(REG_INV_RADIAL, 31'h7FFF_FFFF);
        write_reg(REG_INV_ANGULAR, 31'd1);
        send_cells(FILL_SMALL, 12);
        drain();
        // Shrink the grid under the current position: the stray row emits nothing
        // and wraps back to the origin.
        write_reg(REG_ROW_COUNT, STEP_W'(3));
        send_cells(FILL_SMALL, 3);
        drain();
        // Zero rows run as three.
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, STEP_W'(10));
        write_reg(REG_INV_RADIAL, 31'd65536);
        write_reg(REG_INV_ANGULAR, 31'h7FFF_FFFF);
        send_grid(FILL_RANDOM, 0);
        drain();

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("tb_grid_christoffel_stencil: PASS");
        else
            $display("tb_grid_christoffel_stencil: FAIL");
        $finish;
    end

endmodule
